/* rtl/bilinear_subpixel_image_shift_defines.svh */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_SUBPIXEL_IMAGE_SHIFT_DEFINES_SVH
`define BILINEAR_SUBPIXEL_IMAGE_SHIFT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BSIS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define BSIS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset too
`define BSIS_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bsis_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: package
// Frame geometry, datapath widths, register codes and pipeline stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsis_pkg;

   localparam int IMG_WIDTH  = 64;
   localparam int IMG_HEIGHT = 64;
   localparam int CHANNELS   = 3;
   localparam int FRAC_BITS  = 8;

   localparam int COORD_W  = 6;
   localparam int PLANE_W  = 2;
   localparam int SAMPLE_W = 16;
   localparam int SHIFT_W  = 16;

   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic REG_SHIFT_X = 1'b0;
   localparam logic REG_SHIFT_Y = 1'b1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // 2x2 parity banking: the four neighbors always sit in four different banks
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int HALF_W     = (IMG_WIDTH + 1) / 2;
   localparam int HALF_H     = (IMG_HEIGHT + 1) / 2;
   localparam int HALF_CW    = COORD_W - 1;
   localparam int BANK_DEPTH = HALF_W * HALF_H * CHANNELS;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam int POS_BASE_W = COORD_W + FRAC_BITS + 1;
   localparam int POS_W      = ((POS_BASE_W > SHIFT_W) ? POS_BASE_W : SHIFT_W) + 1;
   localparam int IPART_W    = POS_W - FRAC_BITS;

   localparam int WGT_W = FRAC_BITS + 1;
   localparam int ROW_W = SAMPLE_W + WGT_W;
   localparam int SUM_W = ROW_W + WGT_W;

   typedef struct packed {
      logic                 wr;
      logic                 rd;
      logic                 in_frame;
      logic [COORD_W-1:0]   xi;
      logic [COORD_W-1:0]   yi;
      logic [FRAC_BITS-1:0] xf;
      logic [FRAC_BITS-1:0] yf;
      logic [PLANE_W-1:0]   plane;
      logic [SAMPLE_W-1:0]  wdata;
   } s1_type;

   typedef struct packed {
      logic                 valid;
      logic                 in_frame;
      logic [FRAC_BITS-1:0] xf;
      logic [FRAC_BITS-1:0] yf;
      logic                 xpar;
      logic                 ypar;
   } s2_type;

   typedef struct packed {
      logic                 valid;
      logic                 in_frame;
      logic [FRAC_BITS-1:0] yf;
      logic [ROW_W-1:0]     top;
      logic [ROW_W-1:0]     bot;
   } s3_type;

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [HALF_CW-1:0] xh,
                                                    input logic [HALF_CW-1:0] yh,
                                                    input logic [PLANE_W-1:0] p);
      logic [BANK_AW-1:0] cell_idx;
      cell_idx = BANK_AW'(BANK_AW'(yh) * BANK_AW'(HALF_W)) + BANK_AW'(xh);
      return BANK_AW'(cell_idx * BANK_AW'(CHANNELS)) + BANK_AW'(p);
   endfunction

endpackage

`default_nettype wire

/* rtl/bsis_addr_gen.sv */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: position stage
// Subtracts the shift, splits the source point by floor and checks the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bsis_addr_gen import bsis_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       req_valid,
   input  wire logic                       req_cmd,
   input  wire logic [COORD_W-1:0]         req_col,
   input  wire logic [COORD_W-1:0]         req_row,
   input  wire logic [PLANE_W-1:0]         req_plane,
   input  wire logic [SAMPLE_W-1:0]        req_sample_in,
   input  wire logic signed [SHIFT_W-1:0]  shift_x,
   input  wire logic signed [SHIFT_W-1:0]  shift_y,
   output s1_type                          s1
);

   logic signed [POS_W-1:0]   pos_x;
   logic signed [POS_W-1:0]   pos_y;
   logic signed [IPART_W-1:0] ip_x;
   logic signed [IPART_W-1:0] ip_y;
   logic                      in_x;
   logic                      in_y;
   logic                      addr_ok;
   logic                      is_wr;
   s1_type                    s1_in;
   s1_type                    s1_ff;

   always_comb begin
      pos_x = $signed(POS_W'({req_col, FRAC_BITS'(0)})) - POS_W'(shift_x);
      pos_y = $signed(POS_W'({req_row, FRAC_BITS'(0)})) - POS_W'(shift_y);
      // arithmetic floor: the high bits are the integer part
      ip_x  = pos_x[POS_W-1:FRAC_BITS];
      ip_y  = pos_y[POS_W-1:FRAC_BITS];
      // the right and lower neighbors must also be in the frame
      in_x  = !ip_x[IPART_W-1] && (ip_x <= IPART_W'(IMG_WIDTH - 2));
      in_y  = !ip_y[IPART_W-1] && (ip_y <= IPART_W'(IMG_HEIGHT - 2));
      addr_ok = ({1'b0, req_col} < (COORD_W+1)'(IMG_WIDTH))
             && ({1'b0, req_row} < (COORD_W+1)'(IMG_HEIGHT))
             && ({1'b0, req_plane} < (PLANE_W+1)'(CHANNELS));
      is_wr = (req_cmd == CMD_WRITE);

      s1_in.wr       = req_valid && is_wr && addr_ok;
      s1_in.rd       = req_valid && (req_cmd == CMD_READ);
      s1_in.in_frame = addr_ok && in_x && in_y;
      s1_in.xi       = is_wr ? req_col : ip_x[COORD_W-1:0];
      s1_in.yi       = is_wr ? req_row : ip_y[COORD_W-1:0];
      s1_in.xf       = pos_x[FRAC_BITS-1:0];
      s1_in.yf       = pos_y[FRAC_BITS-1:0];
      s1_in.plane    = req_plane;
      s1_in.wdata    = req_sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.wr <= 1'b0;
         s1_ff.rd <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

`default_nettype wire

/* rtl/bsis_frame_store.sv */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: frame store
// Four parity banks; one write or four neighbor reads per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bsis_frame_store import bsis_pkg::*; (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  s1_type                                   s1,
   output s2_type                                   s2,
   output logic [NUM_BANKS-1:0][SAMPLE_W-1:0]       rd_data
);

   s2_type s2_ff;

   for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
      localparam logic BX = ((k % 2) == 1);
      localparam logic BY = ((k / 2) == 1);

      logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
      logic [SAMPLE_W-1:0] rdata_ff;
      logic [COORD_W-1:0]  xs;
      logic [COORD_W-1:0]  ys;
      logic [BANK_AW-1:0]  raddr;
      logic [BANK_AW-1:0]  waddr;
      logic                we;

      always_comb begin
         // neighbor column/row that has this bank's parity
         xs    = s1.xi + COORD_W'(BX ^ s1.xi[0]);
         ys    = s1.yi + COORD_W'(BY ^ s1.yi[0]);
         raddr = s1.in_frame ? bank_addr(xs[COORD_W-1:1], ys[COORD_W-1:1], s1.plane) : '0;
         waddr = bank_addr(s1.xi[COORD_W-1:1], s1.yi[COORD_W-1:1], s1.plane);
         we    = en && s1.wr && (s1.xi[0] == BX) && (s1.yi[0] == BY);
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= s1.wdata;
         end
         if (en) begin
            rdata_ff <= mem[raddr];
         end
      end

      assign rd_data[k] = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ff.valid <= s1.rd;
      end
      if (en) begin
         s2_ff.in_frame <= s1.in_frame;
         s2_ff.xf       <= s1.xf;
         s2_ff.yf       <= s1.yf;
         s2_ff.xpar     <= s1.xi[0];
         s2_ff.ypar     <= s1.yi[0];
      end
   end

   assign s2 = s2_ff;

endmodule

`default_nettype wire

/* rtl/bsis_blend.sv */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: blend
// Horizontal blend of both rows, then vertical blend, rounding and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bsis_blend import bsis_pkg::*; (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  s2_type                                   s2,
   input  wire logic [NUM_BANKS-1:0][SAMPLE_W-1:0]  rd_data,
   output logic                                     rsp_valid,
   output logic [SAMPLE_W-1:0]                      rsp_sample_out,
   output logic                                     rsp_inside_res
);

   localparam logic [WGT_W-1:0] ONE_W = WGT_W'(1 << FRAC_BITS);
   localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (2 * FRAC_BITS - 1);

   logic [BANK_SEL_W-1:0] sel_a;
   logic [BANK_SEL_W-1:0] sel_b;
   logic [BANK_SEL_W-1:0] sel_c;
   logic [BANK_SEL_W-1:0] sel_d;
   logic [WGT_W-1:0]      wx1;
   logic [WGT_W-1:0]      wy1;
   logic [SUM_W-1:0]      sum;
   logic [SAMPLE_W-1:0]   blended;
   s3_type                s3_in;
   s3_type                s3_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  inside_ff;

   always_comb begin
      // bank = {row parity, column parity}
      sel_a = {s2.ypar, s2.xpar};
      sel_b = {~s2.ypar, s2.xpar};
      sel_c = {s2.ypar, ~s2.xpar};
      sel_d = {~s2.ypar, ~s2.xpar};
      wx1   = ONE_W - WGT_W'(s2.xf);

      s3_in.valid    = s2.valid;
      s3_in.in_frame = s2.in_frame;
      s3_in.yf       = s2.yf;
      s3_in.top      = ROW_W'(rd_data[sel_a]) * ROW_W'(wx1)
                     + ROW_W'(rd_data[sel_c]) * ROW_W'(s2.xf);
      s3_in.bot      = ROW_W'(rd_data[sel_b]) * ROW_W'(wx1)
                     + ROW_W'(rd_data[sel_d]) * ROW_W'(s2.xf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff.valid <= s3_in.valid;
      end
      if (en) begin
         s3_ff.in_frame <= s3_in.in_frame;
         s3_ff.yf       <= s3_in.yf;
         s3_ff.top      <= s3_in.top;
         s3_ff.bot      <= s3_in.bot;
      end
   end

   always_comb begin
      wy1     = ONE_W - WGT_W'(s3_ff.yf);
      sum     = SUM_W'(s3_ff.top) * SUM_W'(wy1)
              + SUM_W'(s3_ff.bot) * SUM_W'(s3_ff.yf) + ROUND;
      blended = sum[2*FRAC_BITS +: SAMPLE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_ff.valid;
      end
      if (en) begin
         sample_ff <= s3_ff.in_frame ? blended : '0;
         inside_ff <= s3_ff.in_frame;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_inside_res = inside_ff;

endmodule

`default_nettype wire

/* rtl/bilinear_subpixel_image_shift.sv */
// A read request passes the s1, s2 and s3 registers and the output register to rsp_valid; writes give no response.
// Throughput: one request per cycle while not stalled; the 4-bank parity store gives all four neighbors in one read.
// The whole pipeline stalls only while the output register holds an untaken response.
// Reset clears the pipeline valid bits and both shift registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: top level
// Frame store with bilinear resampling at a programmable subpixel shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_subpixel_image_shift import bsis_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [PLANE_W-1:0]   req_plane,
   input  wire logic [SAMPLE_W-1:0]  req_sample_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]       rsp_sample_out,
   output logic                      rsp_inside_res,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [CSR_AW-1:0]    paddr,
   input  wire logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]         prdata,
   output logic                      pready
);

   logic                       en;
   logic                       csr_wr;
   logic signed [SHIFT_W-1:0]  shift_x_ff;
   logic signed [SHIFT_W-1:0]  shift_y_ff;
   s1_type                     s1;
   s2_type                     s2;
   logic [NUM_BANKS-1:0][SAMPLE_W-1:0] rd_data;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_SHIFT_X: shift_x_ff <= pwdata[SHIFT_W-1:0];
            REG_SHIFT_Y: shift_y_ff <= pwdata[SHIFT_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SHIFT_X: prdata = CSR_DW'($unsigned(shift_x_ff));
         REG_SHIFT_Y: prdata = CSR_DW'($unsigned(shift_y_ff));
         default:     prdata = '0;
      endcase
   end

   bsis_addr_gen u_addr_gen (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_plane     (req_plane),
      .req_sample_in (req_sample_in),
      .shift_x       (shift_x_ff),
      .shift_y       (shift_y_ff),
      .s1            (s1)
   );

   bsis_frame_store u_frame_store (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .s1      (s1),
      .s2      (s2),
      .rd_data (rd_data)
   );

   bsis_blend u_blend (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .s2             (s2),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule

`default_nettype wire

/* rtl/bsis_port_checker.sv */
// ----------------------------------------------------------------------------
// Bilinear subpixel image shift: port checker
// Port-level properties of the request and response channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_subpixel_image_shift_defines.svh"

module bsis_port_checker import bsis_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SAMPLE_W-1:0] rsp_sample_out,
   input wire logic                rsp_inside_res
);

   `BSIS_ASSERT_NXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "response valid after reset")

   `BSIS_ASSERT_IMP(a_outside_is_zero, clock, reset, rsp_valid && !rsp_inside_res, rsp_sample_out == '0, "outside response carries nonzero sample")

   `BSIS_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty output")

   `BSIS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_inside_res), "stalled response changed")

endmodule

bind bilinear_subpixel_image_shift bsis_port_checker u_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_inside_res (rsp_inside_res)
);

`default_nettype wire
